### sv/lkvc_pkg.sv
// Shared constants for the LRU key/value cache: register map, item codes, config widths.
package lkvc_pkg;

    // configuration register indexes
    localparam int unsigned REG_CAPACITY = 0;

    // capacity register
    localparam int unsigned CAP_BITS  = 5;
    localparam int unsigned CAP_RESET = 16;

    // APB port
    localparam int unsigned APB_ADDR_BITS = 3;
    localparam int unsigned APB_DATA_BITS = 32;

    // item kinds carried on s_tuser
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

endpackage

### sv/lkvc_cell.sv
// One entry of the LRU key/value cache: key, value, valid and recency rank, plus a chain stage.
module lkvc_cell #(
    parameter int  IDX_BITS   = 4,
    parameter int  KEY_BITS   = 16,
    parameter int  VALUE_BITS = 32,
    parameter int  CELL_INDEX = 0,
    parameter type acc_t      = logic,
    parameter type upd_t      = logic
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [KEY_BITS-1:0] cmd_key,
    input  upd_t                upd,
    input  acc_t                acc_in,
    output acc_t                acc_out,
    output logic                valid_out
);

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_INDEX);

    logic                  valid_reg;
    logic [IDX_BITS-1:0]   rank_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] data_reg;
    acc_t                  acc_reg;
    acc_t                  acc_next;
    logic                  match;

    // fold this entry into the running search result from the left neighbor
    always_comb begin
        acc_next = acc_in;
        match    = valid_reg && (key_reg == cmd_key);
        if (match && !acc_in.hit) begin
            acc_next.hit      = 1'b1;
            acc_next.hit_idx  = MY_IDX;
            acc_next.hit_rank = rank_reg;
            acc_next.hit_data = data_reg;
        end
        if (valid_reg && (!acc_in.lru_found || (rank_reg > acc_in.lru_rank))) begin
            acc_next.lru_found = 1'b1;
            acc_next.lru_idx   = MY_IDX;
            acc_next.lru_rank  = rank_reg;
        end
        if (!valid_reg && !acc_in.free_found) begin
            acc_next.free_found = 1'b1;
            acc_next.free_idx   = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else if (upd.en) begin
            if (upd.target == MY_IDX) begin
                rank_reg <= '0;
                if (upd.set_valid) begin
                    valid_reg <= 1'b1;
                end
            end else if (valid_reg && (upd.all || (rank_reg < upd.thr))) begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.en && (upd.target == MY_IDX)) begin
            if (upd.wr_key) begin
                key_reg <= upd.key;
            end
            if (upd.wr_data) begin
                data_reg <= upd.data;
            end
        end
    end

    assign acc_out   = acc_reg;
    assign valid_out = valid_reg;

endmodule

### sv/lru_key_value_cache_core.sv
// Top level of the LRU key/value cache: stream ports, APB capacity register, cell chain, control.
// An item accepted while idle is searched through the cell chain (S_SCAN), then applied in the
// update step (S_UPD), which waits while an unaccepted result is held; the result is registered.
// The search wave walks the chain one cell per cycle; no new item is taken until the update is done.
// Reset (aresetn low, synchronous): all entries invalid, ranks and occupancy zero,
// capacity 16, no result pending. Keys and values of entries are not reset.
module lru_key_value_cache_core #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32,
    localparam int S_DATA_BITS = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    localparam int M_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [S_DATA_BITS-1:0]              s_tdata,   // key, write_value, zero pad
    input  logic                                s_tuser,   // mode
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [M_DATA_BITS-1:0]              m_tdata,   // read_value, zero pad
    output logic                                m_tuser,   // hit
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lkvc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [lkvc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [lkvc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    import lkvc_pkg::*;

    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    // search result that travels down the chain, one cell per cycle
    typedef struct packed {
        logic                  hit;
        logic [IDX_BITS-1:0]   hit_idx;
        logic [IDX_BITS-1:0]   hit_rank;
        logic [VALUE_BITS-1:0] hit_data;
        logic                  lru_found;
        logic [IDX_BITS-1:0]   lru_idx;
        logic [IDX_BITS-1:0]   lru_rank;
        logic                  free_found;
        logic [IDX_BITS-1:0]   free_idx;
    } acc_t;

    // update broadcast to every cell in the same cycle
    typedef struct packed {
        logic                  en;
        logic [IDX_BITS-1:0]   target;     // entry that becomes most recent
        logic                  all;        // age every valid entry (insert into free slot)
        logic [IDX_BITS-1:0]   thr;        // else age valid entries with rank below this
        logic                  set_valid;
        logic                  wr_key;
        logic                  wr_data;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] data;
    } upd_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_BITS-1:0]   cnt_reg, cnt_next;
    logic [CNT_BITS-1:0]   occ_reg, occ_next;
    logic [CAP_BITS-1:0]   cap_reg;
    logic                  mode_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] wval_reg;
    logic                  m_valid_reg, m_valid_next;
    logic                  out_hit_reg, out_hit_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;

    acc_t                  acc_chain [ENTRIES+1];
    acc_t                  tail;
    upd_t                  upd;
    logic [ENTRIES-1:0]    valid_vec;
    logic [CMP_BITS-1:0]   cap_ext;
    logic [CMP_BITS-1:0]   eff_cap;
    logic                  evict;
    logic                  go;
    logic                  s_accept;
    logic                  cfg_write;

    // ------------------------------------------------------------------
    // configuration: capacity at byte address 0
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_BITS'(CAP_RESET);
        end else if (cfg_write && (paddr[APB_ADDR_BITS-1:2] == REG_CAPACITY[APB_ADDR_BITS-3:0])) begin
            cap_reg <= pwdata[CAP_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_BITS-1:2] == REG_CAPACITY[APB_ADDR_BITS-3:0]) begin
            prdata = APB_DATA_BITS'(cap_reg);
        end
    end

    // zero acts as one, anything above the built depth acts as the depth
    always_comb begin
        cap_ext = CMP_BITS'(cap_reg);
        if (cap_ext == '0) begin
            eff_cap = CMP_BITS'(1);
        end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
            eff_cap = CMP_BITS'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    // ------------------------------------------------------------------
    // cell chain; cell 0 starts from an empty search result
    // ------------------------------------------------------------------
    assign acc_chain[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        lkvc_cell #(
            .IDX_BITS   (IDX_BITS),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .CELL_INDEX (i),
            .acc_t      (acc_t),
            .upd_t      (upd_t)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd_key   (key_reg),
            .upd       (upd),
            .acc_in    (acc_chain[i]),
            .acc_out   (acc_chain[i+1]),
            .valid_out (valid_vec[i])
        );
    end

    // when the scan ends the chain end holds the full search result
    assign tail = acc_chain[ENTRIES];

    // ------------------------------------------------------------------
    // input capture
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg <= s_tuser;
            key_reg  <= s_tdata[KEY_BITS-1:0];
            wval_reg <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
        end
    end

    // ------------------------------------------------------------------
    // decision and update
    // ------------------------------------------------------------------
    // update waits until the output register can take the result
    assign go    = (state_reg == S_UPD) && (!m_valid_reg || m_tready);
    assign evict = CMP_BITS'(occ_reg) >= eff_cap;

    always_comb begin
        upd           = '0;
        upd.key       = key_reg;
        upd.data      = wval_reg;
        occ_next      = occ_reg;
        upd.en        = go && (tail.hit || (mode_reg == MODE_WRITE));
        if (tail.hit) begin
            // promote the hit entry, overwrite value on a write
            upd.target  = tail.hit_idx;
            upd.thr     = tail.hit_rank;
            upd.wr_data = (mode_reg == MODE_WRITE);
        end else if (evict) begin
            // reuse the least recent entry's slot
            upd.target  = tail.lru_idx;
            upd.thr     = tail.lru_rank;
            upd.wr_key  = 1'b1;
            upd.wr_data = 1'b1;
        end else begin
            // fill the first free slot, everything else ages
            upd.target    = tail.free_idx;
            upd.all       = 1'b1;
            upd.set_valid = 1'b1;
            upd.wr_key    = 1'b1;
            upd.wr_data   = 1'b1;
            if (upd.en) begin
                occ_next = occ_reg + 1'b1;
            end
        end
    end

    always_comb begin
        out_hit_next   = out_hit_reg;
        out_value_next = out_value_reg;
        m_valid_next   = m_valid_reg;
        if (go) begin
            m_valid_next = 1'b1;
            out_hit_next = tail.hit;
            if (mode_reg == MODE_WRITE) begin
                out_value_next = '0;
            end else if (tail.hit) begin
                out_value_next = tail.hit_data;
            end else begin
                out_value_next = '1;
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                cnt_next = '0;
                if (s_accept) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_BITS'(ENTRIES - 1)) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                if (go) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_hit_reg   <= out_hit_next;
        out_value_reg <= out_value_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = M_DATA_BITS'(out_value_reg);

`ifndef ASSERT_OFF
    // occupancy counter tracks the number of valid entries
    a_occ_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(occ_reg))
        else $error("occupancy count differs from valid entries");

    // an insert without eviction always finds a free slot
    a_free_slot_exists: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD && !tail.hit && mode_reg == MODE_WRITE && !evict) |-> tail.free_found)
        else $error("insert found no free slot");

    // an eviction always has a least recent entry to replace
    a_lru_exists: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD && !tail.hit && mode_reg == MODE_WRITE && evict) |-> tail.lru_found)
        else $error("eviction found no valid entry");

    // a result is loaded only on the cycle the update completes
    a_result_after_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_UPD))
        else $error("result raised outside the update step");
`endif

endmodule
